[rtl/snst_pkg.sv]
// Package for the smooth number sequence table.
// Holds table geometry, value limits and the request item type passed between the stages.
// Depends on nothing.
package snst_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int INDEX_WIDTH = 12;
   localparam int VALUE_WIDTH = 63;
   localparam int PTR_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [INDEX_WIDTH:0]   DEPTH_EXT = (INDEX_WIDTH + 1)'(TABLE_DEPTH);
   localparam logic [VALUE_WIDTH-1:0] VALUE_CAP = '1;
   localparam logic [VALUE_WIDTH-1:0] CAP_DIV3  = VALUE_CAP / 3;
   localparam logic [VALUE_WIDTH-1:0] CAP_DIV5  = VALUE_CAP / 5;
   localparam logic [VALUE_WIDTH-1:0] CAP_DIV7  = VALUE_CAP / 7;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] index;
      logic                   out_of_range;
   } snst_item_type;

endpackage

[rtl/smooth_number_sequence_table.sv]
// Top level of the smooth number sequence table (numbers whose only prime factors are 3, 5, 7).
// Connects front stage, item queue and back stage. Depends on snst_pkg, snst_front,
// snst_queue and snst_back.
//
//   channel   ports                                   direction  width
//   request   req_valid, req_stall, req_index         in         12
//   response  rsp_valid, rsp_stall, rsp_value,        out        63 + 1
//             rsp_out_of_range
//
// An in-range request whose entry is already built passes the front register, the queue,
// the back check and a table read before it answers; an out-of-range request answers
// straight from the back stage's pop.
// Each table entry that must still be built adds back-stage steps: three reads through
// the single memory read port, a multiply, a min pass and a write.
// Reset is synchronous; it leaves only entry one of the table defined and needs no
// clearing pass. The front keeps accepting requests while the back stage works or while
// a response waits under rsp_stall, until the front register and both queue slots hold
// requests.
module smooth_number_sequence_table
   import snst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [INDEX_WIDTH-1:0] req_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic                   rsp_out_of_range
);

   // handoff between stages
   logic          push, queue_full, pop, queue_not_empty;
   snst_item_type push_item, pop_item;

   // accept and classify the request
   snst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_index  (req_index),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   // decouple the front from the table extension work
   snst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (queue_not_empty)
   );

   // extend the table as needed and return the entry
   snst_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_not_empty),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

[rtl/snst_front.sv]
// Front stage: accepts requests, flags out-of-range indexes, hands items to the queue.
// Depends on snst_pkg.
module snst_front
   import snst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [INDEX_WIDTH-1:0] req_index,
   output logic                   push,
   output snst_item_type          push_item,
   input  logic                   queue_full
);

   logic          hold_valid_ff, hold_valid_in;
   snst_item_type hold_item_ff, hold_item_in;
   logic          accept;

   always_comb begin
      req_stall     = hold_valid_ff && queue_full;
      accept        = req_valid && !req_stall;
      push          = hold_valid_ff && !queue_full;
      push_item     = hold_item_ff;
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in             = 1'b1;
         hold_item_in.index        = req_index;
         hold_item_in.out_of_range = (req_index == '0) ||
                                     ({1'b0, req_index} >= DEPTH_EXT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

[rtl/snst_queue.sv]
// Short FIFO between the front and back stages.
// Depends on snst_pkg.
module snst_queue
   import snst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  snst_item_type push_item,
   output logic          full,
   input  logic          pop,
   output snst_item_type pop_item,
   output logic          not_empty
);

   snst_item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QPTR_WIDTH + 1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      pop_item  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/snst_back.sv]
// Back stage: extends the sequence table by three-way merging and answers lookups.
// Holds the table memory, merge pointers and the response register. Depends on snst_pkg.
module snst_back
   import snst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  snst_item_type          item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic                   rsp_out_of_range
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_RD5,
      ST_RD7,
      ST_MUL7,
      ST_MIN,
      ST_STEP
   } state_type;

   function automatic logic [VALUE_WIDTH-1:0] mul3(input logic [VALUE_WIDTH-1:0] a);
      logic [VALUE_WIDTH+1:0] p;
      p = {1'b0, a, 1'b0} + {2'b00, a};
      return (a > CAP_DIV3) ? VALUE_CAP : p[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] mul5(input logic [VALUE_WIDTH-1:0] a);
      logic [VALUE_WIDTH+1:0] p;
      p = {a, 2'b00} + {2'b00, a};
      return (a > CAP_DIV5) ? VALUE_CAP : p[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] mul7(input logic [VALUE_WIDTH-1:0] a);
      logic [VALUE_WIDTH+2:0] p;
      p = {a, 3'b000} - {3'b000, a};
      return (a > CAP_DIV7) ? VALUE_CAP : p[VALUE_WIDTH-1:0];
   endfunction

   logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   rd_one_ff;
   logic                   rd_en, wr_en;
   logic [PTR_WIDTH-1:0]   rd_addr, wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_word, least;

   state_type              state_ff, state_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic [PTR_WIDTH-1:0]   p3_ff, p3_in, p5_ff, p5_in, p7_ff, p7_in;
   logic [PTR_WIDTH-1:0]   filled_ff, filled_in;
   logic [VALUE_WIDTH-1:0] c3_ff, c3_in, c5_ff, c5_in, c7_ff, c7_in, m_ff, m_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   // entry one is never written: it reads as 1
   assign rd_word = rd_one_ff ? VALUE_WIDTH'(1) : rd_data_ff;
   assign least   = (m_ff < c7_ff) ? m_ff : c7_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      p3_in        = p3_ff;
      p5_in        = p5_ff;
      p7_in        = p7_ff;
      filled_in    = filled_ff;
      c3_in        = c3_ff;
      c5_in        = c5_ff;
      c7_in        = c7_ff;
      m_in         = m_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = p3_ff;
      wr_en        = 1'b0;
      wr_addr      = filled_ff + 1'b1;
      wr_data      = least;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid && (!rsp_valid_ff || !rsp_stall)) begin
               pop = 1'b1;
               if (item.out_of_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_oor_in   = 1'b1;
               end else begin
                  idx_in   = item.index;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            rd_en = 1'b1;
            if ((INDEX_WIDTH + 1)'(filled_ff) >= (INDEX_WIDTH + 1)'(idx_ff)) begin
               rd_addr  = idx_ff[PTR_WIDTH-1:0];
               state_in = ST_READ;
            end else begin
               rd_addr  = p3_ff;
               state_in = ST_RD5;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_word;
            rsp_oor_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_RD5: begin
            rd_en    = 1'b1;
            rd_addr  = p5_ff;
            c3_in    = mul3(rd_word);
            state_in = ST_RD7;
         end
         ST_RD7: begin
            rd_en    = 1'b1;
            rd_addr  = p7_ff;
            c5_in    = mul5(rd_word);
            state_in = ST_MUL7;
         end
         ST_MUL7: begin
            c7_in    = mul7(rd_word);
            state_in = ST_MIN;
         end
         ST_MIN: begin
            m_in     = (c5_ff < c3_ff) ? c5_ff : c3_ff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // store the least candidate, advance every pointer that produced it
            wr_en     = 1'b1;
            filled_in = filled_ff + 1'b1;
            if (c3_ff == least) p3_in = p3_ff + 1'b1;
            if (c5_ff == least) p5_in = p5_ff + 1'b1;
            if (c7_ff == least) p7_in = p7_ff + 1'b1;
            state_in  = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= value_mem[rd_addr];
         rd_one_ff  <= (rd_addr == PTR_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p3_ff        <= PTR_WIDTH'(1);
         p5_ff        <= PTR_WIDTH'(1);
         p7_ff        <= PTR_WIDTH'(1);
         filled_ff    <= PTR_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p3_ff        <= p3_in;
         p5_ff        <= p5_in;
         p7_ff        <= p7_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      c3_ff        <= c3_in;
      c5_ff        <= c5_in;
      c7_ff        <= c7_in;
      m_ff         <= m_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

[rtl/snst_checker.sv]
// Port-level checker for the smooth number sequence table, with its bind statement.
// Depends on snst_pkg.
module snst_checker
   import snst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic                   rsp_out_of_range
);

   logic [3:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without an outstanding request");

   a_oor_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_value == '0)
      else $error("out-of-range response carries a nonzero value");

   a_in_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_value != '0)
      else $error("in-range response carries zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
                                 $stable(rsp_out_of_range))
      else $error("stalled response changed");

endmodule

bind smooth_number_sequence_table snst_checker u_checker (.*);

[tb/smooth_number_sequence_table_tb.sv]
// Self-checking testbench for smooth_number_sequence_table (3,5,7-smooth sequence lookup).
// Predicts each answer with its own copy of the sequence table and merge pointers.
// Depends on snst_pkg and the smooth_number_sequence_table RTL.
module smooth_number_sequence_table_tb;
   import snst_pkg::*;

   localparam int          CLOCK_HALF     = 5;
   localparam int          RANDOM_COUNT   = 1300;
   localparam int          QUIET_LIMIT    = 40000;
   localparam int          SETTLE_CYCLES  = 24;
   localparam int          REPORT_LINES   = 40;
   localparam int unsigned FACTOR_THREE   = 3;
   localparam int unsigned FACTOR_FIVE    = 5;
   localparam int unsigned FACTOR_SEVEN   = 7;
   localparam int unsigned INDEX_TOP      = (1 << INDEX_WIDTH) - 1;
   localparam logic [63:0] SMOOTH_CAP     = {1'b0, {VALUE_WIDTH{1'b1}}};

   typedef struct {
      logic [INDEX_WIDTH-1:0] index;
      logic [VALUE_WIDTH-1:0] value;
      logic                   out_of_range;
   } smooth_answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [INDEX_WIDTH-1:0] req_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic                   rsp_out_of_range;

   // Predictor state: the sequence built so far and the three merge pointers.
   logic [63:0]            smooth_table [TABLE_DEPTH];
   int unsigned            ptr_three = 1;
   int unsigned            ptr_five = 1;
   int unsigned            ptr_seven = 1;
   int unsigned            entries_built = 1;

   logic [INDEX_WIDTH-1:0] pending_indexes [$];
   smooth_answer_type      awaited_answers [$];
   int                     total_requests = 0;
   int                     requests_sent = 0;
   int                     answers_checked = 0;
   int                     range_rejects = 0;
   int                     mismatch_count = 0;
   int                     quiet_cycles = 0;

   smooth_number_sequence_table uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic logic [63:0] times_capped(logic [63:0] base, int unsigned factor);
      if (base > SMOOTH_CAP / factor) return SMOOTH_CAP;
      return base * factor;
   endfunction

   // Append the next sequence element: least of the three candidates; every
   // pointer whose candidate equals it moves on, so duplicates never land.
   function automatic void grow_table();
      logic [63:0] by_three, by_five, by_seven, least;
      int unsigned slot;
      slot     = entries_built + 1;
      by_three = times_capped(smooth_table[ptr_three], FACTOR_THREE);
      by_five  = times_capped(smooth_table[ptr_five], FACTOR_FIVE);
      by_seven = times_capped(smooth_table[ptr_seven], FACTOR_SEVEN);
      least    = by_three;
      if (by_five < least) least = by_five;
      if (by_seven < least) least = by_seven;
      if (slot < TABLE_DEPTH) smooth_table[slot] = least;
      entries_built = slot;
      if (by_three == least) ptr_three++;
      if (by_five == least) ptr_five++;
      if (by_seven == least) ptr_seven++;
   endfunction

   function automatic void predict_smooth_answer(logic [INDEX_WIDTH-1:0] index);
      smooth_answer_type answer;
      int unsigned       position;
      position     = 32'(index);
      answer.index = index;
      if (position == 0 || position >= TABLE_DEPTH) begin
         answer.value        = '0;
         answer.out_of_range = 1'b1;
      end else begin
         while (entries_built < position) grow_table();
         answer.value        = smooth_table[position][VALUE_WIDTH-1:0];
         answer.out_of_range = 1'b0;
      end
      awaited_answers.push_back(answer);
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Idle rates per third of the run: sender light / receiver heavy, then the
   // reverse, then both at full rate.
   function automatic int sender_gap_pct(int sent);
      if (sent < total_requests / 3) return 6;
      if (sent < 2 * total_requests / 3) return 47;
      return 0;
   endfunction

   function automatic int receiver_stall_pct(int sent);
      if (sent < total_requests / 3) return 47;
      if (sent < 2 * total_requests / 3) return 6;
      return 0;
   endfunction

   // Request driver: record the accepted request, then present the next one
   // unless a gap is rolled. Hold the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_smooth_answer(req_index);
            requests_sent <= requests_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_indexes.size() > 0 &&
                $urandom_range(0, 99) >= sender_gap_pct(requests_sent)) begin
               req_valid <= 1'b1;
               req_index <= pending_indexes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted answer against the oldest prediction.
   always @(posedge clock) begin
      smooth_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("response value %0d with no request pending",
                                         rsp_value));
            end else begin
               want = awaited_answers.pop_front();
               answers_checked++;
               if (want.out_of_range) range_rejects++;
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("index %0d value %0d, want %0d",
                                            want.index, rsp_value, want.value));
               if (rsp_out_of_range !== want.out_of_range)
                  report_mismatch($sformatf("index %0d out_of_range %b, want %b",
                                            want.index, rsp_out_of_range,
                                            want.out_of_range));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct(requests_sent));
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned directed [20] = '{0, INDEX_TOP, TABLE_DEPTH, INDEX_TOP - 1, 1, 1, 2, 3,
                                     4, 7, 5, 12, TABLE_DEPTH + 1, 30, 0, 64, 63, 100,
                                     1, 50};
      int unsigned frontier;
      int unsigned pick;
      int          roll;
      smooth_table[1] = 64'd1;

      // Directed: field extremes, the depth boundary, zero, small growth steps
      // and repeats that must be served from already built entries.
      foreach (directed[i]) pending_indexes.push_back(directed[i][INDEX_WIDTH-1:0]);
      frontier = 100;

      // Random: half the time creep past the built frontier a few entries at a time,
      // mixed with hits below it and out-of-range noise.
      repeat (RANDOM_COUNT) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            pick = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(TABLE_DEPTH, INDEX_TOP);
         end else if (roll < 50) begin
            pick = $urandom_range(1, frontier);
         end else begin
            pick = frontier + $urandom_range(1, 6);
            if (pick > TABLE_DEPTH - 1) pick = TABLE_DEPTH - 1;
            frontier = pick;
         end
         pending_indexes.push_back(pick[INDEX_WIDTH-1:0]);
      end
      total_requests = pending_indexes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait for all requests out and every answer back, then settle.
      do @(negedge clock);
      while (pending_indexes.size() != 0 || req_valid || awaited_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d index requests and checked %0d answers (%0d out of range).",
               requests_sent, answers_checked, range_rejects);
      $display("Sequence grown to %0d entries under three idle/stall mixes.", entries_built);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
